// File: sv/pild_pkg.sv
// Package for the positional insert list: sizes, result kinds, cell commands.
// Used by pild_cell and positional_insert_list_dump; depends on nothing.
package pild_pkg;

  localparam int CAPACITY = 32;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_FORWARD = 2'd1,
    KIND_REVERSE = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROT_L  = 2'd2,
    CELL_ROT_R  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [POS_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
  } cell_cmd_t;

endpackage

// File: sv/pild_cell.sv
// One cell of the list ring: holds one element and takes a new value or a neighbor's value.
// Depends on pild_pkg for widths and the command struct.
module pild_cell (
  input  logic                                  clk,
  input  pild_pkg::cell_cmd_t                   cmd,
  input  logic [pild_pkg::IDX_W-1:0]            my_index,
  input  logic signed [pild_pkg::VAL_W-1:0]     new_value,
  input  logic signed [pild_pkg::VAL_W-1:0]     prev_value,
  input  logic signed [pild_pkg::VAL_W-1:0]     next_value,
  output logic signed [pild_pkg::VAL_W-1:0]     value
);

  logic signed [pild_pkg::VAL_W-1:0] val_r;
  logic signed [pild_pkg::VAL_W-1:0] val_nxt;
  logic [pild_pkg::POS_W-1:0]        idx_ext;
  logic [pild_pkg::POS_W-1:0]        cnt_ext;

  assign idx_ext = pild_pkg::POS_W'(my_index);
  assign cnt_ext = pild_pkg::POS_W'(cmd.count);

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      pild_pkg::CELL_INSERT: begin
        if (idx_ext == cmd.pos) begin
          val_nxt = new_value;
        end else if (idx_ext > cmd.pos && idx_ext <= cnt_ext) begin
          val_nxt = prev_value;
        end
      end
      pild_pkg::CELL_ROT_L: val_nxt = next_value;
      pild_pkg::CELL_ROT_R: val_nxt = prev_value;
      default:              val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value = val_r;

endmodule

// File: sv/positional_insert_list_dump.sv
// Top level of the positional insert list: controller and the ring of cells.
// Depends on pild_pkg and pild_cell.
//
// Usage: present in_position and in_new_value with start; the transaction is
// accepted at a rising edge where start is high and busy is low. Results come
// out one per cycle on out_result_kind, out_element_value and out_last_of_run,
// each valid for exactly one cycle while out_valid is high; the receiver
// cannot stall them.
// A position above the current count, or any valid position into a full list,
// gives one result in the cycle after acceptance, and busy stays low, so the
// next transaction can be taken right away.
// A valid insert takes effect at the accepting edge. The list of n elements
// (after the insert) is then streamed front to back and back to front, one
// result per cycle, each result registered from the ST_FWD or ST_REV state;
// busy stays high until the reverse pass ends, so no new start is accepted.
// The stream comes from rotating the ring of cells one step per cycle, left
// for the forward pass and right for the reverse pass, which restores it.
// Synchronous active-low reset empties the list; cell contents are not reset.
module positional_insert_list_dump (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [pild_pkg::POS_W-1:0]            in_position,
  input  logic signed [pild_pkg::VAL_W-1:0]     in_new_value,
  output logic                                  out_valid,
  output logic [1:0]                            out_result_kind,
  output logic signed [pild_pkg::VAL_W-1:0]     out_element_value,
  output logic                                  out_last_of_run
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FWD  = 3'b010,
    ST_REV  = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [pild_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [pild_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic                                out_valid_r, out_valid_nxt;
  pild_pkg::kind_t                     kind_r, kind_nxt;
  logic signed [pild_pkg::VAL_W-1:0]   value_r, value_nxt;
  logic                                last_r, last_nxt;
  pild_pkg::cell_cmd_t                 cmd;
  logic                                accept;
  logic                                idx_last;
  logic signed [pild_pkg::VAL_W-1:0]   cell_val [pild_pkg::CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < pild_pkg::CAPACITY; gi++) begin : g_cell
      pild_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .my_index   (pild_pkg::IDX_W'(gi)),
        .new_value  (in_new_value),
        .prev_value (cell_val[(gi + pild_pkg::CAPACITY - 1) % pild_pkg::CAPACITY]),
        .next_value (cell_val[(gi + 1) % pild_pkg::CAPACITY]),
        .value      (cell_val[gi])
      );
    end
  endgenerate

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign idx_last = ((pild_pkg::CNT_W'(idx_r) + pild_pkg::CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    cmd.op        = pild_pkg::CELL_HOLD;
    cmd.pos       = in_position;
    cmd.count     = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_position > pild_pkg::POS_W'(count_r)) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = pild_pkg::KIND_INVALID;
            value_nxt     = '0;
            last_nxt      = 1'b1;
          end else if (count_r == pild_pkg::CNT_W'(pild_pkg::CAPACITY)) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = pild_pkg::KIND_FULL;
            value_nxt     = '0;
            last_nxt      = 1'b1;
          end else begin
            cmd.op    = pild_pkg::CELL_INSERT;
            count_nxt = count_r + pild_pkg::CNT_W'(1);
            idx_nxt   = '0;
            state_nxt = ST_FWD;
          end
        end
      end
      ST_FWD: begin
        out_valid_nxt = 1'b1;
        kind_nxt      = pild_pkg::KIND_FORWARD;
        value_nxt     = cell_val[0];
        last_nxt      = idx_last;
        cmd.op        = pild_pkg::CELL_ROT_L;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_REV;
        end else begin
          idx_nxt = idx_r + pild_pkg::IDX_W'(1);
        end
      end
      ST_REV: begin
        out_valid_nxt = 1'b1;
        kind_nxt      = pild_pkg::KIND_REVERSE;
        value_nxt     = cell_val[pild_pkg::CAPACITY-1];
        last_nxt      = idx_last;
        cmd.op        = pild_pkg::CELL_ROT_R;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + pild_pkg::IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_element_value = value_r;
  assign out_last_of_run   = last_r;

  a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == pild_pkg::KIND_INVALID ||
                  out_result_kind == pild_pkg::KIND_FULL)
    |-> out_last_of_run && out_element_value == '0)
    else $error("Rejected transaction result is not a single zero result.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pild_pkg::CNT_W'(pild_pkg::CAPACITY))
    else $error("Element count exceeds capacity.");

  a_fwd_to_rev: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FWD && idx_last |=> state_r == ST_REV && out_last_of_run)
    else $error("Forward pass did not end in the reverse pass.");

  a_rev_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REV && idx_last |=> !busy && out_valid && out_last_of_run)
    else $error("Reverse pass did not end the transaction.");

endmodule
